// File: hdl/phcg_pkg.sv
package phcg_pkg;

   // number of clock edges from the start transfer to the edge that takes the result
   localparam int LATENCY     = 23;
   localparam int CANVAS_MAX  = 64;
   localparam int COORD_W     = 9;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int SCALE_W     = 5;

   localparam logic [4:0] SCALE_MIN = 5'd1;
   localparam logic [4:0] SCALE_MAX = 5'd20;
   localparam logic [6:0] RST_WIDTH  = 7'd64;
   localparam logic [6:0] RST_HEIGHT = 7'd64;
   localparam logic [4:0] RST_SCALE  = 5'd8;

   // Q16 constants
   localparam logic [16:0] Q_ONE        = 17'd65536;
   localparam logic [16:0] Q_SQRT3      = 17'd113512;
   localparam logic [16:0] Q_RAMP_START = 17'd36045;
   localparam logic [17:0] Q_RAMP_SLOPE = 18'd144179;
   // 20 * one * 2, numerator factor of the inner ratio
   localparam logic [21:0] INNER_NUM    = 22'd2621440;

   // square root: 45-bit radicand, 23 result bits, three steps per stage
   localparam int ISQ_W     = 45;
   localparam int ISQ_ITERS = 23;
   localparam int ISQ_PER   = 3;
   localparam int ISQ_STG   = (ISQ_ITERS + ISQ_PER - 1) / ISQ_PER;

   localparam int RECIP_SH = 35;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_SCALE  = 2'd2
   } csr_index_type;

   typedef logic [31:0][31:0] recip_arr_type;

   typedef struct packed {
      logic signed [9:0] val;
      logic [16:0]       err;
   } rnd_type;

   typedef struct packed {
      logic [7:0] ring;
      logic [1:0] phase;
      logic [7:0] tag;
   } side_type;

   // ceil(2^RECIP_SH / d) by restoring long division
   function automatic logic [31:0] ceil_recip(input longint d);
      longint rem;
      longint quo;
      rem = 0;
      quo = 0;
      for (int b = RECIP_SH; b >= 0; b--) begin
         rem = (rem << 1) | ((b == RECIP_SH) ? 64'd1 : 64'd0);
         if (rem >= d) begin
            rem = rem - d;
            quo = quo | (64'd1 << b);
         end
      end
      return 32'(quo + ((rem != 0) ? 64'd1 : 64'd0));
   endfunction

   // ceil(2^35 / (6*s)), divisor of the axial rounding
   function automatic recip_arr_type build_loc_recip();
      recip_arr_type t;
      longint        d;
      for (int i = 0; i < 32; i++) begin
         d    = (i < 3) ? 64'd18 : 64'(6 * i);
         t[i] = ceil_recip(d);
      end
      return t;
   endfunction

   // ceil(2^35 / (18*s)), divisor of the inner ratio
   function automatic recip_arr_type build_inner_recip();
      recip_arr_type t;
      longint        d;
      for (int i = 0; i < 32; i++) begin
         d    = (i < 3) ? 64'd54 : 64'(18 * i);
         t[i] = ceil_recip(d);
      end
      return t;
   endfunction

   localparam recip_arr_type LOC_RECIP   = build_loc_recip();
   localparam recip_arr_type INNER_RECIP = build_inner_recip();

endpackage

// File: hdl/pixel_hex_cell_geometry.sv
// Pixel to flat-top hex cell geometry, fully pipelined.
// Throughput: one pixel per clock, start is taken whenever busy is low.
// The result strobe rsp_valid is carried by a shift register of valid bits beside the data
// path; the path runs through the 8-stage square root and the reciprocal dividers.
// Reset (synchronous, active high) empties the pipe and restores 64, 64, 8 in the registers.
// The receiver cannot stall: every result is shown for exactly one cycle.
module pixel_hex_cell_geometry #(
   parameter int CANVAS_MAX = phcg_pkg::CANVAS_MAX
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [5:0]                      req_pixel_x,
   input  logic [5:0]                      req_pixel_y,
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_ring_distance,
   output logic [1:0]                      rsp_column_phase,
   output logic [7:0]                      rsp_cell_tag,
   output logic [7:0]                      rsp_edge_level,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [phcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [phcg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int LAT    = phcg_pkg::LATENCY;
   localparam int SIDE_N = LAT - 4;
   localparam int IW     = phcg_pkg::ISQ_W;
   localparam int NSTG   = phcg_pkg::ISQ_STG;

   // ---------------- control and registers ----------------
   logic                busy_ff;
   logic [LAT-1:0]      vld_ff, vld_in;
   logic [6:0]          width_ff, height_ff;
   logic [4:0]          scale_ff;
   logic                acc;

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;
   assign acc       = start & ~busy_ff;
   assign vld_in    = {vld_ff[LAT-2:0], acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         vld_ff    <= '0;
         width_ff  <= phcg_pkg::RST_WIDTH;
         height_ff <= phcg_pkg::RST_HEIGHT;
         scale_ff  <= phcg_pkg::RST_SCALE;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= vld_in;
         if (csr_valid && csr_ready) begin
            case (phcg_pkg::csr_index_type'(csr_index))
               phcg_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[6:0];
               phcg_pkg::CSR_HEIGHT: height_ff <= csr_wdata[6:0];
               phcg_pkg::CSR_SCALE:  scale_ff  <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
   end

   // clamped configuration
   logic [phcg_pkg::COORD_W-1:0] w_c, h_c;
   logic [4:0]                   sc_c, s_c;
   logic [6:0]                   s3;

   always_comb begin
      if (width_ff == 7'd0)                 w_c = 9'd1;
      else if (32'(width_ff) > CANVAS_MAX)  w_c = 9'(CANVAS_MAX);
      else                                  w_c = 9'(width_ff);
      if (height_ff == 7'd0)                h_c = 9'd1;
      else if (32'(height_ff) > CANVAS_MAX) h_c = 9'(CANVAS_MAX);
      else                                  h_c = 9'(height_ff);
      if (scale_ff < phcg_pkg::SCALE_MIN)      sc_c = phcg_pkg::SCALE_MIN;
      else if (scale_ff > phcg_pkg::SCALE_MAX) sc_c = phcg_pkg::SCALE_MAX;
      else                                     sc_c = scale_ff;
      s_c = sc_c + 5'd2;
      s3  = 7'(s_c) * 7'd3;
   end

   // ---------------- stage 1: locate numerators ----------------
   // lane 0 is the pixel, lane 1 the canvas centre; both in half pixels
   logic [26:0] aq_ff [2], aq_in [2];
   logic [26:0] ar_ff [2], ar_in [2];
   logic        nr_ff [2], nr_in [2];
   logic [5:0]  px1_ff, py1_ff;

   always_comb begin
      logic [8:0]         xh [2];
      logic [8:0]         yh [2];
      logic signed [27:0] nr;
      logic [27:0]        mr;
      xh[0] = {2'b0, req_pixel_x, 1'b0};
      yh[0] = {2'b0, req_pixel_y, 1'b0};
      xh[1] = w_c;
      yh[1] = h_c;
      for (int l = 0; l < 2; l++) begin
         aq_in[l] = (27'(xh[l]) << 18) + 27'(s3);
         nr       = $signed(28'(yh[l]) * 28'(phcg_pkg::Q_SQRT3)) - $signed(28'(xh[l]) << 16);
         mr       = nr[27] ? 28'(-nr) : 28'(nr);
         nr_in[l] = nr[27];
         ar_in[l] = 27'((mr << 1) + 28'(s3));
      end
   end

   always_ff @(posedge clock) begin
      aq_ff  <= aq_in;
      ar_ff  <= ar_in;
      nr_ff  <= nr_in;
      px1_ff <= req_pixel_x;
      py1_ff <= req_pixel_y;
   end

   // ---------------- stage 2: divide by 6s via reciprocal ----------------
   logic [23:0] mq_ff [2], mq_in [2];
   logic [23:0] mr_ff [2], mr_in [2];
   logic        nr2_ff [2];
   logic [5:0]  px2_ff, py2_ff;

   always_comb begin
      logic [58:0] pq, pr;
      for (int l = 0; l < 2; l++) begin
         pq       = 59'(aq_ff[l]) * 59'(phcg_pkg::LOC_RECIP[s_c]);
         pr       = 59'(ar_ff[l]) * 59'(phcg_pkg::LOC_RECIP[s_c]);
         mq_in[l] = pq[58:35];
         mr_in[l] = pr[58:35];
      end
   end

   always_ff @(posedge clock) begin
      mq_ff  <= mq_in;
      mr_ff  <= mr_in;
      nr2_ff <= nr_ff;
      px2_ff <= px1_ff;
      py2_ff <= py1_ff;
   end

   // ---------------- stage 3: cube component rounding ----------------
   function automatic phcg_pkg::rnd_type cube_rnd(input logic signed [25:0] v);
      phcg_pkg::rnd_type o;
      logic [25:0]       m, rs;
      logic [9:0]        ri;
      m     = v[25] ? 26'(-v) : 26'(v);
      ri    = 10'((m + 26'd32768) >> 16);
      rs    = 26'(ri) << 16;
      o.val = v[25] ? 10'(-ri) : ri;
      o.err = (m >= rs) ? 17'(m - rs) : 17'(rs - m);
      return o;
   endfunction

   phcg_pkg::rnd_type rx_ff [2], ry_ff [2], rz_ff [2];
   phcg_pkg::rnd_type rx_in [2], ry_in [2], rz_in [2];
   logic [5:0]        px3_ff, py3_ff;

   always_comb begin
      logic signed [25:0] fx, fz, fy;
      for (int l = 0; l < 2; l++) begin
         fx       = $signed(26'(mq_ff[l]));
         fz       = nr2_ff[l] ? -$signed(26'(mr_ff[l])) : $signed(26'(mr_ff[l]));
         fy       = -fx - fz;
         rx_in[l] = cube_rnd(fx);
         ry_in[l] = cube_rnd(fy);
         rz_in[l] = cube_rnd(fz);
      end
   end

   always_ff @(posedge clock) begin
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      rz_ff  <= rz_in;
      px3_ff <= px2_ff;
      py3_ff <= py2_ff;
   end

   // ---------------- stage 4: fix the component with the largest error ----------------
   logic signed [9:0] q_ff [2], q_in [2];
   logic signed [9:0] r_ff [2], r_in [2];
   logic [5:0]        px4_ff, py4_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         q_in[l] = rx_ff[l].val;
         r_in[l] = rz_ff[l].val;
         if (rx_ff[l].err > ry_ff[l].err && rx_ff[l].err > rz_ff[l].err)
            q_in[l] = -ry_ff[l].val - rz_ff[l].val;
         else if (!(ry_ff[l].err > rz_ff[l].err))
            r_in[l] = -rx_ff[l].val - ry_ff[l].val;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      px4_ff <= px3_ff;
      py4_ff <= py3_ff;
   end

   // ---------------- stage 5: ring, tag, centre products ----------------
   phcg_pkg::side_type side_ff [SIDE_N];
   phcg_pkg::side_type side_in;
   logic signed [16:0] u_ff, u_in, t_ff, t_in;
   logic [5:0]         px5_ff, py5_ff;

   always_comb begin
      logic signed [11:0] dq, dr, dd;
      logic [11:0]        sum;
      logic [7:0]         tg;
      dq  = 12'(q_ff[0]) - 12'(q_ff[1]);
      dr  = 12'(r_ff[0]) - 12'(r_ff[1]);
      dd  = dq + dr;
      sum = (dq[11] ? 12'(-dq) : 12'(dq)) + (dr[11] ? 12'(-dr) : 12'(dr))
          + (dd[11] ? 12'(-dd) : 12'(dd));
      sum = sum >> 1;
      tg  = 8'(q_ff[0]) * 8'd7 + 8'(r_ff[0]) * 8'd13;
      side_in.ring  = (sum > 12'd255) ? 8'd255 : sum[7:0];
      side_in.phase = q_ff[0][1:0];
      side_in.tag   = tg;
      u_in = $signed({10'b0, s3}) * 17'(q_ff[0]);
      t_in = $signed({12'b0, s_c}) * (17'(q_ff[0]) + (17'(r_ff[0]) <<< 1));
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < SIDE_N; k++) side_ff[k] <= side_ff[k-1];
      u_ff   <= u_in;
      t_ff   <= t_in;
      px5_ff <= px4_ff;
      py5_ff <= py4_ff;
   end

   // ---------------- stage 6: offsets to cell centre ----------------
   logic [21:0] adx_ff, adx_in, ady_ff, ady_in;

   always_comb begin
      logic signed [35:0] dyp, dx, dy;
      logic [35:0]        m, rq;
      dx     = $signed(36'(px5_ff) << 16) - (36'(u_ff) <<< 14);
      dyp    = 36'(t_ff) * $signed({19'b0, phcg_pkg::Q_SQRT3});
      m      = dyp[35] ? 36'(-dyp) : 36'(dyp);
      rq     = (m + 36'd2) >> 2;
      dy     = $signed(36'(py5_ff) << 16) - (dyp[35] ? -$signed(rq) : $signed(rq));
      adx_in = dx[35] ? 22'(-dx) : dx[21:0];
      ady_in = dy[35] ? 22'(-dy) : dy[21:0];
   end

   always_ff @(posedge clock) begin
      adx_ff <= adx_in;
      ady_ff <= ady_in;
   end

   // ---------------- stage 7/8: squares and sum ----------------
   logic [43:0]   sqx_ff, sqy_ff;
   logic [IW-1:0] rad_ff;

   always_ff @(posedge clock) begin
      sqx_ff <= 44'(adx_ff) * 44'(adx_ff);
      sqy_ff <= 44'(ady_ff) * 44'(ady_ff);
      rad_ff <= IW'(sqx_ff) + IW'(sqy_ff);
   end

   // ---------------- stages 9..16: digit-by-digit square root ----------------
   logic [IW-1:0] rem_ff [NSTG], rem_in [NSTG];
   logic [IW-1:0] res_ff [NSTG], res_in [NSTG];

   always_comb begin
      logic [IW-1:0] n, rs, bt;
      int            i;
      for (int k = 0; k < NSTG; k++) begin
         n  = (k == 0) ? rad_ff : rem_ff[(k == 0) ? 0 : k-1];
         rs = (k == 0) ? '0     : res_ff[(k == 0) ? 0 : k-1];
         for (int j = 0; j < phcg_pkg::ISQ_PER; j++) begin
            i = k * phcg_pkg::ISQ_PER + j;
            if (i < phcg_pkg::ISQ_ITERS) begin
               bt = IW'(1) << (2 * (phcg_pkg::ISQ_ITERS - 1 - i));
               if (n >= rs + bt) begin
                  n  = n - (rs + bt);
                  rs = (rs >> 1) + bt;
               end else begin
                  rs = rs >> 1;
               end
            end
         end
         rem_in[k] = n;
         res_in[k] = rs;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   // ---------------- stage 17: rounding of the root ----------------
   logic [23:0] dist_ff;

   always_ff @(posedge clock) begin
      dist_ff <= 24'(res_ff[NSTG-1]) + 24'(rem_ff[NSTG-1] > res_ff[NSTG-1]);
   end

   // ---------------- stages 18..20: inner = round(dist*20/(9s)) ----------------
   logic [45:0] ain_ff;
   logic        clamp_ff;
   logic [25:0] a26_ff;
   logic [16:0] inner_ff, inner_in;

   always_comb begin
      logic [57:0] p;
      logic [22:0] qv;
      p  = 58'(a26_ff) * 58'(phcg_pkg::INNER_RECIP[s_c]);
      qv = p[57:35];
      if (clamp_ff || qv > 23'(phcg_pkg::Q_ONE)) inner_in = phcg_pkg::Q_ONE;
      else                                       inner_in = qv[16:0];
   end

   always_ff @(posedge clock) begin
      ain_ff   <= 46'(dist_ff) * 46'(phcg_pkg::INNER_NUM) + 46'(9 * 46'(s_c));
      clamp_ff <= ain_ff >= (46'(18 * 46'(s_c)) << 17);
      a26_ff   <= ain_ff[25:0];
      inner_ff <= inner_in;
   end

   // ---------------- stages 21..23: edge ramp and byte ----------------
   logic        ramp_ff;
   logic [32:0] te_ff;
   logic [16:0] edge_ff, edge_in;
   logic [7:0]  lvl_in;

   always_comb begin
      logic [17:0] rd;
      logic [24:0] sc;
      rd = 18'((te_ff + 33'd32768) >> 16);
      if (!ramp_ff)                          edge_in = phcg_pkg::Q_ONE;
      else if (rd >= 18'(phcg_pkg::Q_ONE))   edge_in = '0;
      else                                   edge_in = 17'(18'(phcg_pkg::Q_ONE) - rd);
      sc     = (25'(edge_ff) * 25'd255 + 25'd32768) >> 16;
      lvl_in = (sc > 25'd255) ? 8'd255 : sc[7:0];
   end

   always_ff @(posedge clock) begin
      ramp_ff        <= inner_ff > phcg_pkg::Q_RAMP_START;
      te_ff          <= 33'(inner_ff - phcg_pkg::Q_RAMP_START) * 33'(phcg_pkg::Q_RAMP_SLOPE);
      edge_ff        <= edge_in;
      rsp_edge_level <= lvl_in;
   end

   assign rsp_valid         = vld_ff[LAT-1];
   assign rsp_ring_distance = side_ff[SIDE_N-1].ring;
   assign rsp_column_phase  = side_ff[SIDE_N-1].phase;
   assign rsp_cell_tag      = side_ff[SIDE_N-1].tag;

endmodule

// File: hdl/phcg_checker.sv
module phcg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_valid,
   input logic csr_ready
);

   // each start transfer yields exactly one strobe, a fixed number of cycles later
   a_start_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(phcg_pkg::LATENCY) rsp_valid)
      else $error("missing result strobe");

   a_rsp_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, phcg_pkg::LATENCY))
      else $error("result strobe without start");

   a_empty_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("strobe right after reset");

   a_cfg_when_free: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy)
      else $error("csr ready while busy");

endmodule

bind pixel_hex_cell_geometry phcg_checker u_phcg_checker (.*);
